// ----- rtl/lvc_pkg.sv -----
// Shared constants and types for the LRU view cache.
`default_nettype none

package lvc_pkg;

    localparam int ENTRIES    = 8;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int HANDLE_W   = 32;
    localparam int SUB_W      = 16;
    localparam int STAMP_W    = 32;
    localparam int SLOT_W     = 3;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 8;

    typedef logic [IDX_W-1:0] idx_t;

    localparam idx_t LAST_IDX = idx_t'(ENTRIES - 1);

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [SUB_W-1:0]    sub;
        logic [STAMP_W-1:0]  stamp;
    } entry_t;

    typedef struct packed {
        logic   rd_en;
        idx_t   rd_addr;
        logic   wr_en;
        idx_t   wr_addr;
        entry_t wr_data;
    } mem_req_t;

endpackage

`default_nettype wire

// ----- rtl/lru_view_cache_unit.sv -----
// LRU view cache top level: request control, entry scan and write-back.
//
// Fully associative cache of ENTRIES view slots keyed by texture handle and
// subresource index, with timestamp LRU replacement. Keys and stamps live in
// a synchronous memory read one entry per cycle; valid bits are flops. A
// lookup goes through an accept step, one read per entry, a drain step for the
// last read data and a write-back step. A clear or a null-handle lookup goes
// from the accept step straight to the write-back step, with no write. One
// item is worked on at a time; a waiting result holds only the write-back.
`default_nettype none

module lru_view_cache_unit
    import lvc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,  // texture_handle[31:0], sub_index[47:32]
    input  wire logic                  s_tuser,  // action
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata   // ok[0], hit[1], slot[4:2],
                                                 // replaced_valid[5], zero[7:6]
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESP
    } state_t;

    state_t                 state_reg;
    logic [ENTRIES-1:0]     valid_reg;
    logic [STAMP_W-1:0]     use_clock_reg;
    logic                   req_clear_reg;
    logic                   req_null_reg;
    logic [HANDLE_W-1:0]    req_handle_reg;
    logic [SUB_W-1:0]       req_sub_reg;
    idx_t                   scan_idx_reg;
    idx_t                   chk_idx_reg;
    logic                   chk_vld_reg;
    logic                   hit_found_reg, hit_found_next;
    idx_t                   hit_idx_reg, hit_idx_next;
    logic                   free_found_reg, free_found_next;
    idx_t                   free_idx_reg, free_idx_next;
    logic                   min_found_reg, min_found_next;
    idx_t                   min_idx_reg, min_idx_next;
    logic [STAMP_W-1:0]     min_stamp_reg, min_stamp_next;
    logic                   m_tvalid_reg;
    logic [OUT_DATA_W-1:0]  m_tdata_reg;

    mem_req_t               mem_req;
    entry_t                 rd_data;
    logic                   out_free;
    logic                   is_lookup;
    idx_t                   tgt_idx;
    logic [STAMP_W-1:0]     stamp_new;
    logic                   res_ok;
    logic                   res_hit;
    logic [SLOT_W-1:0]      res_slot;
    logic                   res_repl;

    lvc_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign is_lookup = !req_clear_reg && !req_null_reg;
    assign stamp_new = use_clock_reg + STAMP_W'(1);

    always_comb
    begin
        if (hit_found_reg)
        begin
            tgt_idx = hit_idx_reg;
        end
        else if (free_found_reg)
        begin
            tgt_idx = free_idx_reg;
        end
        else
        begin
            tgt_idx = min_idx_reg;
        end
    end

    // scan of one entry per cycle: first hit, first free, oldest valid
    always_comb
    begin
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        min_found_next  = min_found_reg;
        min_idx_next    = min_idx_reg;
        min_stamp_next  = min_stamp_reg;
        if (chk_vld_reg)
        begin
            if (valid_reg[chk_idx_reg] && !hit_found_reg &&
                rd_data.handle == req_handle_reg && rd_data.sub == req_sub_reg)
            begin
                hit_found_next = 1'b1;
                hit_idx_next   = chk_idx_reg;
            end
            if (!valid_reg[chk_idx_reg] && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = chk_idx_reg;
            end
            if (valid_reg[chk_idx_reg] &&
                (!min_found_reg || rd_data.stamp < min_stamp_reg))
            begin
                min_found_next = 1'b1;
                min_idx_next   = chk_idx_reg;
                min_stamp_next = rd_data.stamp;
            end
        end
    end

    always_comb
    begin
        mem_req.rd_en          = (state_reg == ST_SCAN);
        mem_req.rd_addr        = scan_idx_reg;
        mem_req.wr_en          = (state_reg == ST_RESP) && out_free && is_lookup;
        mem_req.wr_addr        = tgt_idx;
        mem_req.wr_data.handle = req_handle_reg;
        mem_req.wr_data.sub    = req_sub_reg;
        mem_req.wr_data.stamp  = stamp_new;
    end

    always_comb
    begin
        res_ok   = !req_null_reg;
        res_hit  = is_lookup && hit_found_reg;
        res_slot = is_lookup ? SLOT_W'(tgt_idx) : '0;
        res_repl = is_lookup && !hit_found_reg && !free_found_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            use_clock_reg  <= '0;
            req_clear_reg  <= 1'b0;
            req_null_reg   <= 1'b0;
            req_handle_reg <= '0;
            req_sub_reg    <= '0;
            scan_idx_reg   <= '0;
            chk_idx_reg    <= '0;
            chk_vld_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            hit_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            min_found_reg  <= 1'b0;
            min_idx_reg    <= '0;
            min_stamp_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && state_reg != ST_RESP)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    chk_vld_reg <= 1'b0;
                    if (s_tvalid)
                    begin
                        req_clear_reg  <= s_tuser;
                        req_null_reg   <= !s_tuser && (s_tdata[HANDLE_W-1:0] == '0);
                        req_handle_reg <= s_tdata[HANDLE_W-1:0];
                        req_sub_reg    <= s_tdata[HANDLE_W +: SUB_W];
                        scan_idx_reg   <= '0;
                        hit_found_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        min_found_reg  <= 1'b0;
                        if (s_tuser)
                        begin
                            valid_reg     <= '0;
                            use_clock_reg <= '0;
                        end
                        if (!s_tuser && s_tdata[HANDLE_W-1:0] != '0)
                        begin
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_RESP;
                        end
                    end
                end
                ST_SCAN:
                begin
                    chk_vld_reg    <= 1'b1;
                    chk_idx_reg    <= scan_idx_reg;
                    hit_found_reg  <= hit_found_next;
                    hit_idx_reg    <= hit_idx_next;
                    free_found_reg <= free_found_next;
                    free_idx_reg   <= free_idx_next;
                    min_found_reg  <= min_found_next;
                    min_idx_reg    <= min_idx_next;
                    min_stamp_reg  <= min_stamp_next;
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + idx_t'(1);
                    end
                end
                ST_DRAIN:
                begin
                    chk_vld_reg    <= 1'b0;
                    hit_found_reg  <= hit_found_next;
                    hit_idx_reg    <= hit_idx_next;
                    free_found_reg <= free_found_next;
                    free_idx_reg   <= free_idx_next;
                    min_found_reg  <= min_found_next;
                    min_idx_reg    <= min_idx_next;
                    min_stamp_reg  <= min_stamp_next;
                    state_reg      <= ST_RESP;
                end
                ST_RESP:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {2'b00, res_repl, res_slot, res_hit, res_ok};
                        if (is_lookup)
                        begin
                            valid_reg[tgt_idx] <= 1'b1;
                            use_clock_reg      <= stamp_new;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lvc_store.sv -----
// Entry store: key and stamp memory, one write and one registered read port.
`default_nettype none

module lvc_store
    import lvc_pkg::*;
(
    input  wire logic     clk,
    input  wire mem_req_t req,
    output entry_t        rd_data
);

    entry_t mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb_lru_view_cache_unit.sv -----
// Testbench for lru_view_cache_unit: random and directed lookups checked against an LRU predictor.
`timescale 1ns / 100ps

module tb_lru_view_cache_unit;
    import lvc_pkg::*;

    localparam int  CYCLE_LIMIT = 1_500_000;
    localparam int  POOL_SIZE   = 12;
    localparam bit  ACT_LOOKUP  = 1'b0;
    localparam bit  ACT_CLEAR   = 1'b1;

    typedef struct {
        bit                  action;
        logic [HANDLE_W-1:0] handle;
        logic [SUB_W-1:0]    sub;
    } view_req_t;

    typedef struct {
        bit              ok;
        bit              hit;
        logic [SLOT_W-1:0] slot;
        bit              replaced;
    } view_res_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    view_req_t pending_q[$];
    view_res_t lookup_result_q[$];
    view_req_t cur_req;
    bit        cur_busy = 1'b0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int cycle_count = 0;

    // predictor state
    bit                  c_valid[ENTRIES];
    logic [HANDLE_W-1:0] c_handle[ENTRIES];
    logic [SUB_W-1:0]    c_sub[ENTRIES];
    logic [STAMP_W-1:0]  c_stamp[ENTRIES];
    logic [STAMP_W-1:0]  c_clock = '0;

    logic [HANDLE_W-1:0] pool_handle[POOL_SIZE];
    logic [SUB_W-1:0]    pool_sub[POOL_SIZE];

    lru_view_cache_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // texture_handle[31:0], sub_index[47:32]
        .s_tuser  (s_tuser),   // action
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // ok[0], hit[1], slot[4:2], replaced_valid[5], zero[7:6]
    );

    always #6 clk = ~clk;

    function automatic view_res_t predict_view(view_req_t rq);
        view_res_t r;
        int        i;
        int        victim;
        bit        found;
        r = '{default: '0};
        if (rq.action == ACT_CLEAR)
        begin
            for (i = 0; i < ENTRIES; i++)
            begin
                c_valid[i]  = 1'b0;
                c_handle[i] = '0;
                c_sub[i]    = '0;
                c_stamp[i]  = '0;
            end
            c_clock = '0;
            r.ok = 1'b1;
            return r;
        end
        if (rq.handle == '0)
            return r;
        c_clock = c_clock + STAMP_W'(1);
        for (i = 0; i < ENTRIES; i++)
        begin
            if (c_valid[i] && c_handle[i] == rq.handle && c_sub[i] == rq.sub)
            begin
                c_stamp[i] = c_clock;
                r.ok   = 1'b1;
                r.hit  = 1'b1;
                r.slot = SLOT_W'(i);
                return r;
            end
        end
        victim = 0;
        found  = 1'b0;
        for (i = 0; i < ENTRIES; i++)
        begin
            if (!c_valid[i])
            begin
                victim = i;
                break;
            end
            if (!found || c_stamp[i] < c_stamp[victim])
            begin
                victim = i;
                found  = 1'b1;
            end
        end
        r.ok       = 1'b1;
        r.slot     = SLOT_W'(victim);
        r.replaced = c_valid[victim];
        c_valid[victim]  = 1'b1;
        c_handle[victim] = rq.handle;
        c_sub[victim]    = rq.sub;
        c_stamp[victim]  = c_clock;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                lookup_result_q.push_back(predict_view(cur_req));
                cur_busy = 1'b0;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_req  = pending_q.pop_front();
                    cur_busy = 1'b1;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_req.sub, cur_req.handle};
                    s_tuser  <= cur_req.action;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        view_res_t w;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (lookup_result_q.size() == 0)
                begin
                    report_mismatch("unexpected item", int'(m_tdata), 0);
                end
                else
                begin
                    w = lookup_result_q.pop_front();
                    if (m_tdata[0] !== w.ok)
                        report_mismatch("ok", int'(m_tdata[0]), int'(w.ok));
                    if (m_tdata[1] !== w.hit)
                        report_mismatch("hit", int'(m_tdata[1]), int'(w.hit));
                    if (m_tdata[4:2] !== w.slot)
                        report_mismatch("slot", int'(m_tdata[4:2]), int'(w.slot));
                    if (m_tdata[5] !== w.replaced)
                        report_mismatch("replaced_valid", int'(m_tdata[5]),
                                        int'(w.replaced));
                    if (m_tdata[7:6] !== 2'b00)
                        report_mismatch("pad bits", int'(m_tdata[7:6]), 0);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic view_req_t mk_req(bit action, logic [HANDLE_W-1:0] h,
                                         logic [SUB_W-1:0] s);
        view_req_t rq;
        rq.action = action;
        rq.handle = h;
        rq.sub    = s;
        return rq;
    endfunction

    function automatic view_req_t random_req();
        int        pick;
        int        k;
        view_req_t rq;
        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, POOL_SIZE - 1);
        if (pick < 3)
        begin
            rq = mk_req(ACT_CLEAR, $urandom, SUB_W'($urandom_range(0, 65535)));
        end
        else if (pick < 7)
        begin
            rq = mk_req(ACT_LOOKUP, '0, SUB_W'($urandom_range(0, 65535)));
        end
        else if (pick < 17)
        begin
            rq = mk_req(ACT_LOOKUP, $urandom, SUB_W'($urandom_range(0, 65535)));
            if (rq.handle == '0)
                rq.handle = 32'h1;
            if ($urandom_range(0, 1))
            begin
                pool_handle[k] = rq.handle;
                pool_sub[k]    = rq.sub;
            end
        end
        else
        begin
            rq = mk_req(ACT_LOOKUP, pool_handle[k], pool_sub[k]);
        end
        return rq;
    endfunction

    task automatic wait_drained();
        while (pending_q.size() != 0 || cur_busy || lookup_result_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int ph;
        int n;
        for (int i = 0; i < ENTRIES; i++)
        begin
            c_valid[i]  = 1'b0;
            c_handle[i] = '0;
            c_sub[i]    = '0;
            c_stamp[i]  = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_handle[i] = $urandom_range(1, 32'h7fff_ffff) | ($urandom & 32'h8000_0000);
            pool_sub[i]    = SUB_W'($urandom_range(0, 65535));
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: clear with full key fields, null, extremes, fill, hit, evictions
        pending_q.push_back(mk_req(ACT_CLEAR, 32'hFFFF_FFFF, 16'hFFFF));
        pending_q.push_back(mk_req(ACT_LOOKUP, 32'h0, 16'hFFFF));
        pending_q.push_back(mk_req(ACT_LOOKUP, 32'hFFFF_FFFF, 16'h0000));
        pending_q.push_back(mk_req(ACT_LOOKUP, 32'hFFFF_FFFF, 16'h0000));
        pending_q.push_back(mk_req(ACT_LOOKUP, 32'h0000_0001, 16'hFFFF));
        pending_q.push_back(mk_req(ACT_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF));
        for (int i = 0; i < 5; i++)
            pending_q.push_back(mk_req(ACT_LOOKUP, 32'hA5A5_0000 + i, 16'h5A5A));
        pending_q.push_back(mk_req(ACT_LOOKUP, 32'h0000_0001, 16'hFFFF));
        pending_q.push_back(mk_req(ACT_LOOKUP, 32'h1234_5678, 16'h8000));
        pending_q.push_back(mk_req(ACT_LOOKUP, 32'h8765_4321, 16'h0001));
        pending_q.push_back(mk_req(ACT_LOOKUP, 32'hFFFF_FFFF, 16'h0000));
        pending_q.push_back(mk_req(ACT_LOOKUP, 32'h0, 16'h0000));
        pending_q.push_back(mk_req(ACT_LOOKUP, 32'h0000_0001, 16'hFFFF));
        pending_q.push_back(mk_req(ACT_CLEAR, 32'h0, 16'h0000));
        pending_q.push_back(mk_req(ACT_LOOKUP, 32'h0000_0001, 16'hFFFF));
        pending_q.push_back(mk_req(ACT_LOOKUP, 32'h1234_5678, 16'h8000));
        wait_drained();

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 81;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 81;
                end
                default:
                begin
                    send_idle_pct = 10;
                    recv_stall_pct = 10;
                end
            endcase
            for (n = 0; n < 445; n++)
            begin
                pending_q.push_back(random_req());
                if (pending_q.size() > 16)
                    @(posedge clk);
            end
            wait_drained();
        end

        repeat (30) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- lru_view_cache_unit.f -----
rtl/lvc_pkg.sv
rtl/lvc_store.sv
rtl/lru_view_cache_unit.sv
tb/tb_lru_view_cache_unit.sv
